// ----- rtl/core/lamp_delay_fade_ramp_top_assert.svh -----
// assertion macros for the lamp fade ramp block
`ifndef LAMP_DELAY_FADE_RAMP_TOP_ASSERT_SVH
`define LAMP_DELAY_FADE_RAMP_TOP_ASSERT_SVH

// same-cycle implication, checked on the block clock outside reset
`define LDFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the block clock outside reset
`define LDFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ldfr_pkg.sv -----
// shared types and constants of the lamp fade ramp block
package ldfr_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned CfgIdxW  = 2;
  // 100 * 0xFFFF fits in 23 bits
  localparam int unsigned NumW     = 23;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned DivCntW  = 3;

  localparam logic [TimerW-1:0] TimerMax = 16'hFFFF;
  localparam logic [DutyW-1:0]  FullDuty = 7'd100;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegOnDelay  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOffDelay = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOnRamp   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOffRamp  = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StDiv,
    StFin
  } state_e;

endpackage

// ----- rtl/core/ldfr_if.sv -----
// valid/ready channels for tick items and ramp results
interface ldfr_tick_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 request_on;
  logic [ldfr_pkg::TickW-1:0]           tick_ms;

  modport source (output valid, output request_on, output tick_ms, input ready);
  modport sink   (input valid, input request_on, input tick_ms, output ready);
endinterface

interface ldfr_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 lamp_active;
  logic [ldfr_pkg::DutyW-1:0]           duty_percent;

  modport source (output valid, output lamp_active, output duty_percent, input ready);
  modport sink   (input valid, input lamp_active, input duty_percent, output ready);
endinterface

// ----- rtl/core/lamp_delay_fade_ramp_top.sv -----
// delayed fade-in / fade-out ramp for one lamp channel
//
//  channel   dir  payload                      transfer when
//  tick_i    in   request_on, tick_ms          valid & ready
//  res_o     out  lamp_active, duty_percent    valid & ready
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i   cfg_we_i high
//
// an item that needs the percent ratio goes from transfer in to result through
// the accept state, the timer update state, the steps of the bit-serial
// restoring divider and the load of the result register; an item without
// a ratio skips the divider.
// reset is asynchronous active low and clears timers, flags and duty.
// a new tick is taken while a finished result waits on res_o; the block
// stalls in its last cycle only until the result register is free.
module lamp_delay_fade_ramp_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ldfr_tick_if.sink                           tick_i,
  ldfr_res_if.source                          res_o,
  input  logic                                cfg_we_i,
  input  logic [ldfr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ldfr_pkg::TimerW-1:0]         cfg_data_i
);

  // configuration registers
  logic [ldfr_pkg::TimerW-1:0] on_delay_q, off_delay_q, on_ramp_q, off_ramp_q;

  // channel state
  logic [ldfr_pkg::TimerW-1:0] since_q, since_d;
  logic [ldfr_pkg::TimerW-1:0] ramp_q, ramp_d;
  logic                        last_req_q, last_req_d;
  logic                        active_q, active_d;
  logic [ldfr_pkg::DutyW-1:0]  duty_q, duty_d;

  // captured tick
  logic                        req_q;
  logic [ldfr_pkg::TickW-1:0]  dt_q;

  // divider
  logic [ldfr_pkg::NumW-1:0]    rem_q, rem_d;
  logic [ldfr_pkg::NumW-1:0]    dsh_q, dsh_d;
  logic [ldfr_pkg::DutyW-1:0]   quo_q, quo_d;
  logic                         over_q, over_d;
  logic [ldfr_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         div_q, div_d;
  logic                         div_on_q, div_on_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic                        out_active_q, out_active_d;
  logic [ldfr_pkg::DutyW-1:0]  out_duty_q, out_duty_d;

  ldfr_pkg::state_e state_q, state_d;

  logic                        in_xfer;
  logic                        out_free;
  logic [ldfr_pkg::TimerW:0]   since_sum;
  logic [ldfr_pkg::TimerW-1:0] since_sat;
  logic                        changed;
  logic [ldfr_pkg::TimerW-1:0] since_new;
  logic [ldfr_pkg::TimerW-1:0] ramp_base;
  logic [ldfr_pkg::TimerW:0]   ramp_sum;
  logic [ldfr_pkg::TimerW-1:0] ramp_sat;
  logic [ldfr_pkg::NumW-1:0]   ramp_x100;
  logic                        div_ge;
  logic [ldfr_pkg::DutyW-1:0]  div_duty;

  assign in_xfer  = tick_i.valid && tick_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_delay_q  <= '0;
      off_delay_q <= '0;
      on_ramp_q   <= '0;
      off_ramp_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ldfr_pkg::RegOnDelay:  on_delay_q  <= cfg_data_i;
        ldfr_pkg::RegOffDelay: off_delay_q <= cfg_data_i;
        ldfr_pkg::RegOnRamp:   on_ramp_q   <= cfg_data_i;
        ldfr_pkg::RegOffRamp:  off_ramp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tick capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= tick_i.request_on;
      dt_q  <= tick_i.tick_ms;
    end
  end

  // timer arithmetic for the update cycle
  assign since_sum = {1'b0, since_q} + {{(ldfr_pkg::TimerW+1-ldfr_pkg::TickW){1'b0}}, dt_q};
  assign since_sat = since_sum[ldfr_pkg::TimerW] ? ldfr_pkg::TimerMax
                                                 : since_sum[ldfr_pkg::TimerW-1:0];
  assign changed   = req_q != last_req_q;
  assign since_new = changed ? '0 : since_sat;
  assign ramp_base = changed ? '0 : ramp_q;
  assign ramp_sum  = {1'b0, ramp_base} + {{(ldfr_pkg::TimerW+1-ldfr_pkg::TickW){1'b0}}, dt_q};
  assign ramp_sat  = ramp_sum[ldfr_pkg::TimerW] ? ldfr_pkg::TimerMax
                                                : ramp_sum[ldfr_pkg::TimerW-1:0];
  // 100 = 64 + 32 + 4
  assign ramp_x100 = {1'b0, ramp_sat, 6'b0} + {2'b0, ramp_sat, 5'b0}
                   + {5'b0, ramp_sat, 2'b0};

  // divider step compare and final duty from the quotient
  assign div_ge = rem_q >= dsh_q;
  always_comb begin
    if (div_on_q) begin
      div_duty = (over_q || (quo_q > ldfr_pkg::FullDuty)) ? ldfr_pkg::FullDuty : quo_q;
    end else begin
      div_duty = (over_q || (quo_q >= ldfr_pkg::FullDuty)) ? '0
                                                            : ldfr_pkg::FullDuty - quo_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldfr_pkg::StIdle: if (in_xfer) state_d = ldfr_pkg::StPrep;
      ldfr_pkg::StPrep: state_d = div_d ? ldfr_pkg::StDiv : ldfr_pkg::StFin;
      ldfr_pkg::StDiv:  if (cnt_q == ldfr_pkg::DivCntW'(ldfr_pkg::DivSteps - 1)) begin
        state_d = ldfr_pkg::StFin;
      end
      ldfr_pkg::StFin:  if (out_free) state_d = ldfr_pkg::StIdle;
      default:          state_d = ldfr_pkg::StIdle;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    tick_i.ready = state_q == ldfr_pkg::StIdle;
    since_d      = since_q;
    ramp_d       = ramp_q;
    last_req_d   = last_req_q;
    active_d     = active_q;
    duty_d       = duty_q;
    rem_d        = rem_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    over_d       = over_q;
    cnt_d        = cnt_q;
    div_d        = div_q;
    div_on_d     = div_on_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_active_d = out_active_q;
    out_duty_d   = out_duty_q;
    unique case (state_q)
      ldfr_pkg::StPrep: begin
        since_d    = since_new;
        ramp_d     = ramp_base;
        last_req_d = req_q;
        div_d      = 1'b0;
        div_on_d   = req_q;
        cnt_d      = '0;
        over_d     = 1'b0;
        quo_d      = '0;
        rem_d      = ramp_x100;
        if (req_q) begin
          if (since_new >= on_delay_q) begin
            active_d = 1'b1;
            if (ramp_base < on_ramp_q) begin
              ramp_d = ramp_sat;
              div_d  = 1'b1;
              dsh_d  = {on_ramp_q, 7'b0};
            end else begin
              duty_d = ldfr_pkg::FullDuty;
            end
          end
        end else if (since_new >= off_delay_q) begin
          if (ramp_base < off_ramp_q) begin
            ramp_d = ramp_sat;
            div_d  = 1'b1;
            dsh_d  = {off_ramp_q, 7'b0};
          end else begin
            active_d = 1'b0;
          end
        end
      end
      ldfr_pkg::StDiv: begin
        // first step only checks for a quotient of 128 or more
        if (cnt_q == '0) begin
          over_d = div_ge;
        end else begin
          if (div_ge) rem_d = rem_q - dsh_q;
          quo_d = {quo_q[ldfr_pkg::DutyW-2:0], div_ge};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
      end
      ldfr_pkg::StFin: begin
        if (out_free) begin
          if (div_q) duty_d = div_duty;
          out_valid_d  = 1'b1;
          out_active_d = active_q;
          out_duty_d   = div_q ? div_duty : duty_q;
        end
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldfr_pkg::StIdle;
      since_q     <= '0;
      ramp_q      <= '0;
      last_req_q  <= 1'b0;
      active_q    <= 1'b0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      div_q       <= 1'b0;
      div_on_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      since_q     <= since_d;
      ramp_q      <= ramp_d;
      last_req_q  <= last_req_d;
      active_q    <= active_d;
      duty_q      <= duty_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      div_q       <= div_d;
      div_on_q    <= div_on_d;
    end
  end

  // divider and result payload
  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    dsh_q        <= dsh_d;
    quo_q        <= quo_d;
    over_q       <= over_d;
    out_active_q <= out_active_d;
    out_duty_q   <= out_duty_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.lamp_active  = out_active_q;
  assign res_o.duty_percent = out_duty_q;

`include "lamp_delay_fade_ramp_top_assert.svh"

  `LDFR_ASSERT_IMPL(a_duty_range, out_valid_q, out_duty_q <= ldfr_pkg::FullDuty, "duty above full")
  `LDFR_ASSERT_NEXT(a_accept_prep, in_xfer, state_q == ldfr_pkg::StPrep, "tick not processed")
  `LDFR_ASSERT_IMPL(a_div_nonzero, state_q == ldfr_pkg::StDiv && cnt_q == '0, dsh_q != '0, "zero divisor")
  `LDFR_ASSERT_NEXT(a_fin_load, state_q == ldfr_pkg::StFin && !out_valid_q, out_valid_q, "result lost")

endmodule
